@@ rtl/wind_polar_to_components_macros.svh @@
// Assertion macros for the wind polar-to-components block.
// Included by the top level; needs nothing else.
`ifndef WIND_POLAR_TO_COMPONENTS_MACROS_SVH
`define WIND_POLAR_TO_COMPONENTS_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define WPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define WPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/wpc_pkg.sv @@
// Package for the wind polar-to-components block: field widths, CORDIC
// arctangent table, phase conversion constants and the pipeline tag type.
// Depends on nothing.
package wpc_pkg;

   // Port field widths
   localparam int SPEED_W = 16;
   localparam int DIR_W   = 15;
   localparam int COMP_W  = 17;

   // Parameter defaults
   localparam int SPEED_BITS_DEF      = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 6;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int MAX_STAGES          = 32;

   // Gain compensation: speed times 1/K in Q31, keeping GUARD fraction bits
   localparam int              GUARD      = 14;
   localparam longint unsigned KINV_Q31   = 1304065748;
   localparam int              KINV_W     = 31;
   localparam int              PROD_W     = SPEED_W + KINV_W;
   localparam int              GAIN_SHIFT = 31 - GUARD;
   localparam int              X0_W       = PROD_W + 1 - GAIN_SHIFT;

   // CORDIC datapath widths (signed, with headroom for growth and folding)
   localparam int XY_W = 34;
   localparam int Z_W  = 34;

   // Direction reduction: a full turn is FULL_TURN_DEG degrees
   localparam int FULL_TURN_DEG = 360;
   // Subtract steps for the modulo; covers the smallest full turn in 15 bits
   localparam int MOD_STEPS = 7;

   // Phase = quo * 2^(29-afb) + table[rem] where dir = DIR_DIV*quo + rem
   localparam int DIR_DIV      = 45;
   localparam int PHASE_DIV    = 90;
   localparam int RECIP_SHIFT  = 21;
   localparam int RECIP        = (1 << RECIP_SHIFT) / DIR_DIV;
   localparam int RECIP_W      = 16;
   localparam int QM_W         = DIR_W + RECIP_W;
   localparam int QUO_W        = 10;
   localparam int REM_W        = 6;
   localparam int REM_WIDE_W   = 16;
   localparam int PHASE_W      = 32;
   localparam int PHASE_FRAC   = 29;

   localparam int OUT_MAX = 65535;

   // atan(2^-i) in 2^32-per-turn units
   localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef logic [DIR_DIV-1:0][PHASE_W-1:0] phase_tab_type;

   // Control bits that travel with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic zero;
      logic defined;
   } wpc_tag_type;

   // Fractional phase for each remainder, rounded: (rem*2^(30-afb)+45)/90
   function automatic phase_tab_type build_phase_tab(input int afb);
      phase_tab_type   tab;
      longint unsigned num;
      for (int i = 0; i < DIR_DIV; i++) begin
         num    = (longint'(i) << (30 - afb)) + longint'(PHASE_DIV / 2);
         tab[i] = PHASE_W'(num / PHASE_DIV);
      end
      return tab;
   endfunction

endpackage

@@ rtl/wind_polar_to_components.sv @@
// Wind speed/direction to u/v components, pipelined CORDIC rotation.
// Depends on wpc_pkg and wind_polar_to_components_macros.svh.
//
// Usage:
//   Request channel (req_): wind speed, direction the wind blows from, and
//   a defined flag for each. A transfer happens when req_valid is high and
//   req_stall is low. Response channel (rsp_): u = -speed*sin(dir),
//   v = -speed*cos(dir) and a defined flag; same valid/stall rule.
//   A defined zero speed gives u = v = 0, defined. Any other missing
//   operand gives u = v = 0, undefined.
//   Pipeline from request transfer to rsp_valid: four front stages (gain
//   multiply and direction modulo, reciprocal multiply, quotient fix-up,
//   phase and quadrant fold), one register per CORDIC iteration, one
//   rounding stage.
//   Throughput: one item per cycle while the skid is empty. The pipeline
//   moves as a whole; a one-entry skid buffer behind the output register
//   catches the result when the receiver stalls, and req_stall is simply
//   that buffer's full flag. The whole pipeline holds while the skid drains.
//   Reset (synchronous, active high) empties every stage and the skid.
//   No clearing pass, no configuration.
`include "wind_polar_to_components_macros.svh"

module wind_polar_to_components import wpc_pkg::*; #(
   parameter int SPEED_BITS      = SPEED_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SPEED_W-1:0]       req_wind_speed,
   input  logic                     req_speed_defined,
   input  logic [DIR_W-1:0]         req_wind_direction,
   input  logic                     req_direction_defined,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COMP_W-1:0] rsp_zonal_component,
   output logic signed [COMP_W-1:0] rsp_meridional_component,
   output logic                     rsp_result_defined
);

   localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam longint FULL_TURN = longint'(FULL_TURN_DEG) << ANGLE_FRAC_BITS;
   localparam int PH_SHIFT = PHASE_FRAC - ANGLE_FRAC_BITS;
   localparam phase_tab_type PHASE_TAB = build_phase_tab(ANGLE_FRAC_BITS);
   localparam logic [SPEED_W-1:0] SPEED_MASK = (SPEED_BITS >= SPEED_W) ? '1 :
      SPEED_W'((longint'(1) << SPEED_BITS) - 1);
   localparam logic signed [Z_W-1:0] Q_TURN = Z_W'(longint'(1) << 30);
   localparam logic signed [Z_W-1:0] H_TURN = Z_W'(longint'(1) << 31);
   localparam logic signed [XY_W-1:0] FIN_ROUND = XY_W'(longint'(1) << (GUARD - 1));
   localparam logic signed [XY_W-1:0] SAT_MAX = XY_W'(OUT_MAX);
   localparam logic signed [COMP_W-1:0] COMP_MAX = COMP_W'(OUT_MAX);
   localparam logic signed [COMP_W-1:0] COMP_NEG_FULL = {1'b1, {(COMP_W - 1){1'b0}}};

   // Whole pipeline advances unless the skid holds a result
   logic adv;
   logic skid_valid_ff;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- Stage 1: gain multiply, direction modulo ----------------
   logic [SPEED_W-1:0] speed_m;
   logic [DIR_W-1:0]   dir_rem;
   wpc_tag_type        s1_tag_in, s1_tag_ff;
   logic [PROD_W-1:0]  s1_prod_in, s1_prod_ff;
   logic [DIR_W-1:0]   s1_dir_ff;

   always_comb begin
      speed_m = req_wind_speed & SPEED_MASK;
      // reduce the direction below a full turn by binary compare-subtract
      dir_rem = req_wind_direction;
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (32'(dir_rem) >= 32'(FULL_TURN << k)) begin
            dir_rem = dir_rem - DIR_W'(FULL_TURN << k);
         end
      end
      s1_prod_in        = PROD_W'(speed_m) * PROD_W'(KINV_Q31);
      s1_tag_in.valid   = req_valid;
      s1_tag_in.zero    = !req_speed_defined || (speed_m == '0) || !req_direction_defined;
      s1_tag_in.defined = req_speed_defined && ((speed_m == '0) || req_direction_defined);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else if (adv) begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s1_dir_ff  <= dir_rem;
      end
   end

   // ---------------- Stage 2: round gain, reciprocal multiply ----------------
   wpc_tag_type       s2_tag_ff;
   logic [X0_W-1:0]   s2_x0_in, s2_x0_ff;
   logic [QM_W-1:0]   s2_qm_in, s2_qm_ff;
   logic [DIR_W-1:0]  s2_dir_ff;
   logic [PROD_W:0]   gain_sum;

   always_comb begin
      gain_sum = (PROD_W + 1)'(s1_prod_ff) + (PROD_W + 1)'(longint'(1) << (GAIN_SHIFT - 1));
      s2_x0_in = X0_W'(gain_sum >> GAIN_SHIFT);
      s2_qm_in = QM_W'(s1_dir_ff) * QM_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
      end else if (adv) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x0_ff  <= s2_x0_in;
         s2_qm_ff  <= s2_qm_in;
         s2_dir_ff <= s1_dir_ff;
      end
   end

   // ---------------- Stage 3: fix up quotient and remainder ----------------
   wpc_tag_type           s3_tag_ff;
   logic [X0_W-1:0]       s3_x0_ff;
   logic [QUO_W-1:0]      quo_est, s3_quo_in, s3_quo_ff;
   logic [REM_WIDE_W-1:0] rem_wide;
   logic [REM_W-1:0]      s3_rem_in, s3_rem_ff;

   always_comb begin
      // estimate is exact or one short
      quo_est  = QUO_W'(s2_qm_ff >> RECIP_SHIFT);
      rem_wide = REM_WIDE_W'(s2_dir_ff)
                 - REM_WIDE_W'(quo_est) * REM_WIDE_W'(DIR_DIV);
      if (rem_wide >= REM_WIDE_W'(DIR_DIV)) begin
         s3_quo_in = quo_est + QUO_W'(1);
         s3_rem_in = REM_W'(rem_wide - REM_WIDE_W'(DIR_DIV));
      end else begin
         s3_quo_in = quo_est;
         s3_rem_in = REM_W'(rem_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
      end else if (adv) begin
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_x0_ff  <= s2_x0_ff;
         s3_quo_ff <= s3_quo_in;
         s3_rem_ff <= s3_rem_in;
      end
   end

   // ---------------- Stage 4: build phase, add half turn, fold ----------------
   wpc_tag_type              s4_tag_ff;
   logic [PHASE_W-1:0]       phase;
   logic signed [Z_W-1:0]    z_raw, s4_z_in, s4_z_ff;
   logic signed [XY_W-1:0]   x_raw, s4_x_in, s4_x_ff;

   always_comb begin
      phase = (PHASE_W'(s3_quo_ff) << PH_SHIFT) + PHASE_TAB[s3_rem_ff];
      // adding half a turn flips the top bit
      z_raw = Z_W'($signed({~phase[PHASE_W-1], phase[PHASE_W-2:0]}));
      x_raw = $signed(XY_W'(s3_x0_ff));
      // fold into the right half plane by negating the start vector
      if (z_raw > Q_TURN) begin
         s4_x_in = -x_raw;
         s4_z_in = z_raw - H_TURN;
      end else if (z_raw < -Q_TURN) begin
         s4_x_in = -x_raw;
         s4_z_in = z_raw + H_TURN;
      end else begin
         s4_x_in = x_raw;
         s4_z_in = z_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_tag_ff <= '0;
      end else if (adv) begin
         s4_tag_ff <= s3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_x_ff <= s4_x_in;
         s4_z_ff <= s4_z_in;
      end
   end

   // ---------------- CORDIC rotation, one iteration per stage ----------------
   wpc_tag_type            ctag_ff [NS];
   logic signed [XY_W-1:0] cx_ff [NS];
   logic signed [XY_W-1:0] cy_ff [NS];
   logic signed [Z_W-1:0]  cz_ff [NS];

   for (genvar c = 0; c < NS; c++) begin : g_cordic
      wpc_tag_type            tag_i;
      logic signed [XY_W-1:0] x_i, y_i, dx, dy, x_in, y_in;
      logic signed [Z_W-1:0]  z_i, z_in, ang;

      if (c == 0) begin : g_first
         assign tag_i = s4_tag_ff;
         assign x_i   = s4_x_ff;
         assign y_i   = '0;
         assign z_i   = s4_z_ff;
      end else begin : g_next
         assign tag_i = ctag_ff[c-1];
         assign x_i   = cx_ff[c-1];
         assign y_i   = cy_ff[c-1];
         assign z_i   = cz_ff[c-1];
      end

      // rotate toward zero residual angle
      always_comb begin
         dx  = y_i >>> c;
         dy  = x_i >>> c;
         ang = $signed(Z_W'(ATAN_TAB[c]));
         if (z_i >= 0) begin
            x_in = x_i - dx;
            y_in = y_i + dy;
            z_in = z_i - ang;
         end else begin
            x_in = x_i + dx;
            y_in = y_i - dy;
            z_in = z_i + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctag_ff[c] <= '0;
         end else if (adv) begin
            ctag_ff[c] <= tag_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[c] <= x_in;
            cy_ff[c] <= y_in;
            cz_ff[c] <= z_in;
         end
      end
   end

   // ---------------- Output stage: round, saturate, force zero ----------------
   wpc_tag_type              out_tag_ff;
   logic signed [XY_W-1:0]   v_rnd, u_rnd;
   logic signed [COMP_W-1:0] out_v_in, out_u_in, out_v_ff, out_u_ff;

   always_comb begin
      v_rnd = (cx_ff[NS-1] + FIN_ROUND) >>> GUARD;
      u_rnd = (cy_ff[NS-1] + FIN_ROUND) >>> GUARD;
      if (v_rnd > SAT_MAX) begin
         out_v_in = COMP_MAX;
      end else if (v_rnd < -SAT_MAX) begin
         out_v_in = -COMP_MAX;
      end else begin
         out_v_in = COMP_W'(v_rnd);
      end
      if (u_rnd > SAT_MAX) begin
         out_u_in = COMP_MAX;
      end else if (u_rnd < -SAT_MAX) begin
         out_u_in = -COMP_MAX;
      end else begin
         out_u_in = COMP_W'(u_rnd);
      end
      if (ctag_ff[NS-1].zero) begin
         out_v_in = '0;
         out_u_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_tag_ff <= '0;
      end else if (adv) begin
         out_tag_ff <= ctag_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_v_ff <= out_v_in;
         out_u_ff <= out_u_in;
      end
   end

   // ---------------- Skid buffer: hold a stalled result ----------------
   logic signed [COMP_W-1:0] skid_v_ff, skid_u_ff;
   logic                     skid_def_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_tag_ff.valid && rsp_stall) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_v_ff   <= out_v_ff;
         skid_u_ff   <= out_u_ff;
         skid_def_ff <= out_tag_ff.defined;
      end
   end

   // Drive the result channel from the skid first, it holds the older item
   always_comb begin
      rsp_valid = skid_valid_ff || out_tag_ff.valid;
      if (skid_valid_ff) begin
         rsp_zonal_component      = skid_u_ff;
         rsp_meridional_component = skid_v_ff;
         rsp_result_defined       = skid_def_ff;
      end else begin
         rsp_zonal_component      = out_u_ff;
         rsp_meridional_component = out_v_ff;
         rsp_result_defined       = out_tag_ff.defined;
      end
   end

   // ---------------- Assertions ----------------
   `WPC_ASSERT_NEXT(a_skid_freezes_pipe, clock, reset, skid_valid_ff, $stable(s1_tag_ff) && $stable(s4_tag_ff) && $stable(out_tag_ff), "pipeline moved while skid held a result")
   `WPC_ASSERT_NEXT(a_stall_fills_skid, clock, reset, rsp_valid && rsp_stall && !skid_valid_ff, skid_valid_ff, "stalled result was not caught by the skid")
   `WPC_ASSERT_SAME(a_undefined_is_zero, clock, reset, rsp_valid && !rsp_result_defined, (rsp_zonal_component == '0) && (rsp_meridional_component == '0), "undefined result with nonzero components")
   `WPC_ASSERT_SAME(a_saturated_range, clock, reset, rsp_valid, (rsp_zonal_component != COMP_NEG_FULL) && (rsp_meridional_component != COMP_NEG_FULL), "component outside saturation range")

endmodule
